// ----- sv/gtpd_pkg.sv -----
`timescale 1ns / 1ps
// Package for the gait-target PD joint controller: widths, reset values,
// register codes and the gait setpoint table. Depends on nothing.
package gtpd_pkg;

   localparam int NUM_JOINTS_DEF      = 12;
   localparam int NUM_GAIT_JOINTS_DEF = 8;

   localparam int SEL_W    = 4;
   localparam int POS_W    = 16;
   localparam int ERR_W    = POS_W + 1;
   localparam int DERR_W   = POS_W + 2;
   localparam int TORQUE_W = 32;
   localparam int GAIN_W   = 8;
   localparam int SDIV_W   = 10;
   localparam int TPP_W    = 12;
   localparam int TICK_W   = 14;
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = 32;

   localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 8'd70;
   localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 8'd50;
   localparam logic [SDIV_W-1:0] SDIV_RST       = 10'd200;
   localparam logic [TPP_W-1:0]  TPP_RST        = 12'd500;
   localparam logic [POS_W-1:0]  HIP_OFFSET_RST = 16'd0;
   localparam logic [TICK_W-1:0] TICK_RST       = 14'd1;

   localparam logic signed [POS_W-1:0] Q_HALF     = 16'sd2048;
   localparam logic signed [POS_W-1:0] Q_ONE      = 16'sd4096;
   localparam logic signed [POS_W-1:0] Q_ONE_HALF = 16'sd6144;
   localparam logic signed [POS_W-1:0] Q_TWO      = 16'sd8192;

   localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
   localparam logic [2:0] REG_DERIV_GAIN = 3'd1;
   localparam logic [2:0] REG_SMOOTH_DIV = 3'd2;
   localparam logic [2:0] REG_TICKS_PP   = 3'd3;
   localparam logic [2:0] REG_HIP_OFFSET = 3'd4;

   typedef logic signed [POS_W-1:0] pos_type;

   function automatic pos_type gait_setpoint(input logic [2:0] row, input logic [1:0] phase);
      pos_type sp;
      sp = Q_HALF;
      case (row)
         3'd0, 3'd3: begin
            case (phase)
               2'd0: sp = Q_TWO;
               2'd1: sp = Q_TWO;
               2'd2: sp = Q_ONE_HALF;
               default: sp = Q_ONE;
            endcase
         end
         3'd1, 3'd2: begin
            case (phase)
               2'd0: sp = Q_ONE_HALF;
               2'd1: sp = Q_ONE;
               2'd2: sp = Q_TWO;
               default: sp = Q_TWO;
            endcase
         end
         3'd4, 3'd7: begin
            case (phase)
               2'd0: sp = Q_ONE_HALF;
               2'd1: sp = Q_HALF;
               2'd2: sp = Q_HALF;
               default: sp = Q_ONE_HALF;
            endcase
         end
         default: begin
            case (phase)
               2'd0: sp = Q_HALF;
               2'd1: sp = Q_ONE_HALF;
               2'd2: sp = Q_ONE_HALF;
               default: sp = Q_HALF;
            endcase
         end
      endcase
      return sp;
   endfunction

endpackage

// ----- sv/gait_target_pd_joint_control.sv -----
`timescale 1ns / 1ps
// Gait-target PD joint controller: target and previous-error memories, a shared
// two-bit-per-cycle divider, PD multipliers, APB register file. Uses gtpd_pkg.
// The sequencer takes one word at a time: req_tready is high only in the idle state, so a
// new word is accepted only once the last one's result word has been loaded. The shared
// divider runs a tick division for every word and a smoothing division for gait joints
// (two divisions per gait word), and a waiting result word holds the sequencer.
// Reset clears the registers to their defaults, sets the tick count to one and
// clears the valid bits, so unwritten memory entries read as their reset values.
module gait_target_pd_joint_control #(
   parameter int NUM_JOINTS      = gtpd_pkg::NUM_JOINTS_DEF,
   parameter int NUM_GAIT_JOINTS = gtpd_pkg::NUM_GAIT_JOINTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // joint_sel [3:0], joint_position [19:4], zero [23:20]
   input  logic [23:0]                 req_tdata,
   input  logic                        req_tlast,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // joint_out [3:0], torque_cmd [35:4], zero [39:36]
   output logic [39:0]                 rsp_tdata,
   // torque_saturated [0]
   output logic [0:0]                  rsp_tuser,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [gtpd_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [gtpd_pkg::DATA_W-1:0] csr_pwdata,
   output logic [gtpd_pkg::DATA_W-1:0] csr_prdata,
   output logic                        csr_pready
);
   import gtpd_pkg::*;

   localparam int GAIT_AW  = (NUM_GAIT_JOINTS > 1) ? $clog2(NUM_GAIT_JOINTS) : 1;
   localparam int PERR_AW  = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
   localparam int DIV_W    = 18;
   localparam int REM_W    = TPP_W + 1;
   localparam int DIV_STEPS = DIV_W / 2;
   localparam int CNT_W    = $clog2(DIV_STEPS);
   localparam int PP_W     = GAIN_W + 1 + ERR_W;
   localparam int PD_W     = GAIN_W + 1 + DERR_W;
   localparam int SUM_W    = PD_W + 1;

   localparam logic [SEL_W:0] NJ_LIM = (SEL_W + 1)'(NUM_JOINTS);
   localparam logic [SEL_W:0] NG_LIM = (SEL_W + 1)'(NUM_GAIT_JOINTS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_TDIV = 3'd1;
   localparam logic [2:0] ST_PREP = 3'd2;
   localparam logic [2:0] ST_SDIV = 3'd3;
   localparam logic [2:0] ST_UPD  = 3'd4;
   localparam logic [2:0] ST_MUL  = 3'd5;
   localparam logic [2:0] ST_SUM  = 3'd6;

   logic [GAIN_W-1:0] prop_gain_ff, deriv_gain_ff;
   logic [SDIV_W-1:0] sdiv_ff;
   logic [TPP_W-1:0]  tpp_ff;
   logic [POS_W-1:0]  hip_offset_ff;
   logic [TICK_W-1:0] tick_ff;

   logic [2:0] state_ff, state_in;
   logic [SEL_W-1:0] sel_ff;
   pos_type pos_ff;
   logic last_ff;

   pos_type tgt_mem [NUM_GAIT_JOINTS];
   logic signed [ERR_W-1:0] perr_mem [NUM_JOINTS];
   logic [NUM_GAIT_JOINTS-1:0] tgt_vld_ff;
   logic [NUM_JOINTS-1:0] perr_vld_ff;
   pos_type tgt_rd_ff;
   logic signed [ERR_W-1:0] perr_rd_ff;
   logic tgt_rd_vld_ff, perr_rd_vld_ff;

   logic [REM_W-1:0] div_rem_ff, div_rem_in, step_rem;
   logic [DIV_W-1:0] div_quo_ff, div_quo_in, step_quo;
   logic [TPP_W-1:0] div_dsr_ff, div_dsr_in;
   logic [CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [REM_W-1:0] trial;

   pos_type cur_tgt_ff;
   logic diff_neg_ff;
   logic signed [ERR_W-1:0] err_ff;
   logic signed [DERR_W-1:0] derr_ff;
   logic signed [PP_W-1:0] prod_p_ff;
   logic signed [PD_W-1:0] prod_d_ff;

   logic rsp_tvalid_ff;
   logic [SEL_W-1:0] rsp_sel_ff;
   logic [TORQUE_W-1:0] rsp_torque_ff;
   logic rsp_sat_ff;

   logic req_acc, csr_wr, is_joint, is_gait, rsp_load;
   logic [SEL_W-1:0] req_sel;
   logic [TPP_W-1:0] tpp_eff;
   logic [SDIV_W-1:0] sdiv_eff;
   logic [2:0] row;
   pos_type sp_raw, sp, cur_tgt, new_tgt;
   logic signed [POS_W:0] hip_sum, diff, step_s, tgt_sum;
   logic [POS_W:0] diff_mag;
   logic [TICK_W-1:0] tick_mod, tick_nxt, cyc;
   logic signed [ERR_W-1:0] err_c, perr_cur;
   logic signed [DERR_W-1:0] derr_c;
   logic signed [SUM_W-1:0] sum_c;
   logic signed [TORQUE_W:0] sum_w;
   logic [TORQUE_W-1:0] torque_c;
   logic sat_c;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign req_sel    = req_tdata[SEL_W-1:0];
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign is_joint = ({1'b0, sel_ff} < NJ_LIM);
   assign is_gait  = ({1'b0, sel_ff} < NG_LIM);
   assign tpp_eff  = (tpp_ff == '0) ? TPP_W'(1) : tpp_ff;
   assign sdiv_eff = (sdiv_ff == '0) ? SDIV_W'(1) : sdiv_ff;
   assign row      = sel_ff[2:0];

   // Register file.
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= PROP_GAIN_RST;
         deriv_gain_ff <= DERIV_GAIN_RST;
         sdiv_ff       <= SDIV_RST;
         tpp_ff        <= TPP_RST;
         hip_offset_ff <= HIP_OFFSET_RST;
      end else if (csr_wr) begin
         case (csr_paddr[4:2])
            REG_PROP_GAIN:  prop_gain_ff  <= csr_pwdata[GAIN_W-1:0];
            REG_DERIV_GAIN: deriv_gain_ff <= csr_pwdata[GAIN_W-1:0];
            REG_SMOOTH_DIV: sdiv_ff       <= csr_pwdata[SDIV_W-1:0];
            REG_TICKS_PP:   tpp_ff        <= csr_pwdata[TPP_W-1:0];
            REG_HIP_OFFSET: hip_offset_ff <= csr_pwdata[POS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         REG_PROP_GAIN:  csr_prdata = DATA_W'(prop_gain_ff);
         REG_DERIV_GAIN: csr_prdata = DATA_W'(deriv_gain_ff);
         REG_SMOOTH_DIV: csr_prdata = DATA_W'(sdiv_ff);
         REG_TICKS_PP:   csr_prdata = DATA_W'(tpp_ff);
         REG_HIP_OFFSET: csr_prdata = DATA_W'($signed(hip_offset_ff));
         default:        csr_prdata = '0;
      endcase
   end

   // Two restoring division steps per cycle.
   always_comb begin
      step_rem = div_rem_ff;
      step_quo = div_quo_ff;
      trial    = '0;
      for (int i = 0; i < 2; i++) begin
         trial = {step_rem[REM_W-2:0], step_quo[DIV_W-1]};
         if (trial >= {1'b0, div_dsr_ff}) begin
            step_rem = trial - {1'b0, div_dsr_ff};
            step_quo = {step_quo[DIV_W-2:0], 1'b1};
         end else begin
            step_rem = trial;
            step_quo = {step_quo[DIV_W-2:0], 1'b0};
         end
      end
   end

   // Tick arithmetic from the tick division: quotient gives the phase.
   always_comb begin
      cyc      = {tpp_eff, 2'b00};
      tick_mod = TICK_W'(TICK_W'(div_quo_ff[1:0]) * TICK_W'(tpp_eff)) + TICK_W'(div_rem_ff);
      tick_nxt = tick_mod + TICK_W'(1);
      if (tick_nxt == cyc) begin
         tick_nxt = '0;
      end
   end

   // Setpoint and smoothing difference.
   always_comb begin
      sp_raw  = gait_setpoint(row, div_quo_ff[1:0]);
      hip_sum = (POS_W + 1)'(sp_raw) + (POS_W + 1)'($signed(hip_offset_ff));
      if (hip_sum > (POS_W + 1)'(17'sd32767)) begin
         hip_sum = 17'sd32767;
      end else if (hip_sum < -(POS_W + 1)'(17'sd32768)) begin
         hip_sum = -17'sd32768;
      end
      sp       = row[2] ? hip_sum[POS_W-1:0] : sp_raw;
      cur_tgt  = tgt_rd_vld_ff ? tgt_rd_ff : (row[2] ? Q_HALF : Q_ONE_HALF);
      diff     = (POS_W + 1)'(sp) - (POS_W + 1)'(cur_tgt);
      diff_mag = diff[POS_W] ? (POS_W + 1)'(-diff) : (POS_W + 1)'(diff);
   end

   // Target update, error and derivative term.
   always_comb begin
      step_s   = diff_neg_ff ? -$signed(div_quo_ff[POS_W:0]) : $signed(div_quo_ff[POS_W:0]);
      tgt_sum  = (POS_W + 1)'(cur_tgt_ff) + step_s;
      new_tgt  = is_gait ? tgt_sum[POS_W-1:0] : pos_type'(0);
      err_c    = ERR_W'(new_tgt) - ERR_W'(pos_ff);
      perr_cur = perr_rd_vld_ff ? perr_rd_ff : '0;
      derr_c   = DERR_W'(err_c) - DERR_W'(perr_cur);
      sum_c    = SUM_W'(prod_p_ff) + SUM_W'(prod_d_ff);
      sum_w    = (TORQUE_W + 1)'(sum_c);
      sat_c    = 1'b0;
      torque_c = sum_w[TORQUE_W-1:0];
      if (sum_w > 33'sh0_7FFF_FFFF) begin
         torque_c = 32'h7FFF_FFFF;
         sat_c    = 1'b1;
      end else if (sum_w < 33'sh1_8000_0000) begin
         torque_c = 32'h8000_0000;
         sat_c    = 1'b1;
      end
      if (!is_joint) begin
         torque_c = '0;
         sat_c    = 1'b0;
      end
   end

   assign rsp_load = (state_ff == ST_SUM) && (!rsp_tvalid_ff || rsp_tready);

   // Sequencer and divider control.
   always_comb begin
      state_in   = state_ff;
      div_rem_in = div_rem_ff;
      div_quo_in = div_quo_ff;
      div_dsr_in = div_dsr_ff;
      div_cnt_in = div_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               div_rem_in = '0;
               div_quo_in = DIV_W'(tick_ff);
               div_dsr_in = tpp_eff;
               div_cnt_in = '0;
               state_in   = ST_TDIV;
            end
         end
         ST_TDIV, ST_SDIV: begin
            div_rem_in = step_rem;
            div_quo_in = step_quo;
            div_cnt_in = div_cnt_ff + CNT_W'(1);
            if (div_cnt_ff == CNT_LAST) begin
               state_in = (state_ff == ST_TDIV) ? ST_PREP : ST_UPD;
            end
         end
         ST_PREP: begin
            if (is_gait) begin
               div_rem_in = '0;
               div_quo_in = DIV_W'(diff_mag);
               div_dsr_in = TPP_W'(sdiv_eff);
               div_cnt_in = '0;
               state_in   = ST_SDIV;
            end else begin
               state_in = ST_UPD;
            end
         end
         ST_UPD:  state_in = ST_MUL;
         ST_MUL:  state_in = ST_SUM;
         ST_SUM: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         tick_ff        <= TICK_RST;
         tgt_vld_ff     <= '0;
         perr_vld_ff    <= '0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_PREP && last_ff) begin
            tick_ff <= tick_nxt;
         end
         if (state_ff == ST_UPD && is_gait) begin
            tgt_vld_ff[sel_ff[GAIT_AW-1:0]] <= 1'b1;
         end
         if (state_ff == ST_UPD && is_joint) begin
            perr_vld_ff[sel_ff[PERR_AW-1:0]] <= 1'b1;
         end
         rsp_tvalid_ff <= rsp_load || (rsp_tvalid_ff && !rsp_tready);
      end
   end

   // State memories: registered read at acceptance, write-back at update.
   always_ff @(posedge clock) begin
      if (req_acc && ({1'b0, req_sel} < NG_LIM)) begin
         tgt_rd_ff     <= tgt_mem[req_sel[GAIT_AW-1:0]];
         tgt_rd_vld_ff <= tgt_vld_ff[req_sel[GAIT_AW-1:0]];
      end
      if (req_acc && ({1'b0, req_sel} < NJ_LIM)) begin
         perr_rd_ff     <= perr_mem[req_sel[PERR_AW-1:0]];
         perr_rd_vld_ff <= perr_vld_ff[req_sel[PERR_AW-1:0]];
      end
      if (state_ff == ST_UPD && is_gait) begin
         tgt_mem[sel_ff[GAIT_AW-1:0]] <= new_tgt;
      end
      if (state_ff == ST_UPD && is_joint) begin
         perr_mem[sel_ff[PERR_AW-1:0]] <= err_c;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
      div_dsr_ff <= div_dsr_in;
      div_cnt_ff <= div_cnt_in;
      if (req_acc) begin
         sel_ff  <= req_sel;
         pos_ff  <= req_tdata[SEL_W +: POS_W];
         last_ff <= req_tlast;
      end
      if (state_ff == ST_PREP) begin
         cur_tgt_ff  <= cur_tgt;
         diff_neg_ff <= diff[POS_W];
      end
      if (state_ff == ST_UPD) begin
         err_ff  <= err_c;
         derr_ff <= derr_c;
      end
      if (state_ff == ST_MUL) begin
         prod_p_ff <= $signed({1'b0, prop_gain_ff}) * err_ff;
         prod_d_ff <= $signed({1'b0, deriv_gain_ff}) * derr_ff;
      end
      if (rsp_load) begin
         rsp_sel_ff    <= sel_ff;
         rsp_torque_ff <= torque_c;
         rsp_sat_ff    <= sat_c;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {4'b0000, rsp_torque_ff, rsp_sel_ff};
   assign rsp_tuser  = rsp_sat_ff;

endmodule
